[sv/mlfsp_pkg.sv]
// ----------------------------------------------------------------------------
// mlfsp_pkg
// Types and constants of the magic-byte, length-prefixed frame speed parser.
// ----------------------------------------------------------------------------
package mlfsp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned SPEED_W    = 32;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_BYTE    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_COMMAND = 8'd1;

   localparam logic [BYTE_W-1:0] MAGIC_BYTE_RESET    = 8'd250;
   localparam logic [BYTE_W-1:0] SPEED_COMMAND_RESET = 8'h02;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_CMD     = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_TRAILER = 3'd5
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] magic_byte;
      logic [BYTE_W-1:0] speed_command;
   } cfg_type;

   typedef struct packed {
      logic [SPEED_W-1:0] left_speed_bits;
      logic [SPEED_W-1:0] right_speed_bits;
      logic [LEN_W-1:0]   frame_length;
      logic               payload_truncated;
   } result_type;

endpackage

[sv/magic_length_frame_speed_parser.sv]
// ----------------------------------------------------------------------------
// magic_length_frame_speed_parser
// Hunts for the magic byte, reads command, length, payload and trailer, and
// returns the wheel speed words at the end of each speed frame.
//
//   channel  direction  handshake         payload
//   req      in         valid / stall     rx_byte (8)
//   rsp      out        valid / stall     left, right (32 each), length (16),
//                                         truncated (1)
//   csr      in         valid / ready     index (8), data (8)
//
// One byte per cycle unless the result stalls; a byte waits in the byte
// register and steps through the frame state logic to the result register.
// Synchronous active-high reset clears the state, the speed store and both
// valid flags. A stalled result holds the byte stage, which then stalls req.
// ----------------------------------------------------------------------------
module magic_length_frame_speed_parser #(
   parameter int unsigned TRAILER_BYTES = 2,
   parameter int unsigned SPEED_BYTES   = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mlfsp_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mlfsp_pkg::SPEED_W-1:0]         rsp_left_speed_bits,
   output logic [mlfsp_pkg::SPEED_W-1:0]         rsp_right_speed_bits,
   output logic [mlfsp_pkg::LEN_W-1:0]           rsp_frame_length,
   output logic                                  rsp_payload_truncated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mlfsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mlfsp_pkg::CSR_DATA_W-1:0]      csr_data
);

   mlfsp_pkg::cfg_type               cfg_ff;
   logic                             in_valid_ff;
   logic [mlfsp_pkg::BYTE_W-1:0]     in_byte_ff;
   logic                             out_valid_ff, out_valid_in;
   mlfsp_pkg::result_type            out_res_ff;
   logic                             out_free;
   logic                             step;
   logic                             req_accept;
   logic                             core_valid;
   mlfsp_pkg::result_type            core_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_byte    <= mlfsp_pkg::MAGIC_BYTE_RESET;
         cfg_ff.speed_command <= mlfsp_pkg::SPEED_COMMAND_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mlfsp_pkg::CSR_MAGIC_BYTE:    cfg_ff.magic_byte    <= csr_data;
            mlfsp_pkg::CSR_SPEED_COMMAND: cfg_ff.speed_command <= csr_data;
            default: ;
         endcase
      end
   end

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign step       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mlfsp_core #(
      .TRAILER_BYTES (TRAILER_BYTES),
      .SPEED_BYTES   (SPEED_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg_ff),
      .res_valid (core_valid),
      .res       (core_res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = core_valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && core_valid) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_left_speed_bits   = out_res_ff.left_speed_bits;
   assign rsp_right_speed_bits  = out_res_ff.right_speed_bits;
   assign rsp_frame_length      = out_res_ff.frame_length;
   assign rsp_payload_truncated = out_res_ff.payload_truncated;

   a_stall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with no byte held");

   a_truncated_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload_truncated == (rsp_frame_length > 16'(SPEED_BYTES)))
      else $error("truncation flag disagrees with frame length");

   a_store_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({rsp_right_speed_bits, rsp_left_speed_bits}
                     >> (SPEED_BYTES * mlfsp_pkg::BYTE_W)) == 64'd0)
      else $error("speed bytes beyond the store are not zero");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff && !step |=> !out_valid_ff)
      else $error("result appeared without a processed byte");

endmodule

[sv/mlfsp_core.sv]
// ----------------------------------------------------------------------------
// mlfsp_core
// Frame state machine, byte counter and speed store; one byte per step.
// ----------------------------------------------------------------------------
module mlfsp_core #(
   parameter int unsigned TRAILER_BYTES = 2,
   parameter int unsigned SPEED_BYTES   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [mlfsp_pkg::BYTE_W-1:0]        rx_byte,
   input  mlfsp_pkg::cfg_type                  cfg,
   output logic                                res_valid,
   output mlfsp_pkg::result_type               res
);

   localparam int unsigned STORE_W = SPEED_BYTES * mlfsp_pkg::BYTE_W;

   mlfsp_pkg::phase_type              phase_ff, phase_in;
   logic [mlfsp_pkg::BYTE_W-1:0]      cmd_ff, cmd_in;
   logic [mlfsp_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [mlfsp_pkg::LEN_W-1:0]       count_ff, count_in;
   logic [STORE_W-1:0]                store_ff, store_in;
   logic [mlfsp_pkg::LEN_W-1:0]       count_inc;
   logic [63:0]                       store_wide;
   logic                              payload_done;
   logic                              frame_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mlfsp_pkg::PH_HUNT;
         cmd_ff   <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         store_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         store_ff <= store_in;
      end
   end

   assign count_inc = count_ff + 16'd1;

   always_comb begin
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      store_in     = store_ff;
      payload_done = 1'b0;
      frame_done   = 1'b0;
      unique case (phase_ff)
         mlfsp_pkg::PH_CMD: begin
            cmd_in   = rx_byte;
            phase_in = mlfsp_pkg::PH_LEN_LO;
         end
         mlfsp_pkg::PH_LEN_LO: begin
            len_in   = {8'd0, rx_byte};
            phase_in = mlfsp_pkg::PH_LEN_HI;
         end
         mlfsp_pkg::PH_LEN_HI: begin
            len_in   = {rx_byte, len_ff[7:0]};
            count_in = '0;
            if (len_in == '0) begin
               payload_done = 1'b1;
            end else begin
               phase_in = mlfsp_pkg::PH_PAYLOAD;
            end
         end
         mlfsp_pkg::PH_PAYLOAD: begin
            if (count_ff < 16'(SPEED_BYTES) && cmd_ff == cfg.speed_command) begin
               for (int k = 0; k < int'(SPEED_BYTES); k++) begin
                  if (count_ff == 16'(k)) begin
                     store_in[k*mlfsp_pkg::BYTE_W +: mlfsp_pkg::BYTE_W] = rx_byte;
                  end
               end
            end
            count_in = count_inc;
            if (count_inc >= len_ff) begin
               payload_done = 1'b1;
            end
         end
         mlfsp_pkg::PH_TRAILER: begin
            count_in = count_inc;
            if (count_inc >= 16'(TRAILER_BYTES)) begin
               frame_done = 1'b1;
            end
         end
         default: begin
            phase_in = (rx_byte == cfg.magic_byte) ? mlfsp_pkg::PH_CMD : mlfsp_pkg::PH_HUNT;
         end
      endcase
      if (payload_done) begin
         count_in = '0;
         if (TRAILER_BYTES > 0) begin
            phase_in = mlfsp_pkg::PH_TRAILER;
         end else begin
            frame_done = 1'b1;
         end
      end
      if (frame_done) begin
         phase_in = mlfsp_pkg::PH_HUNT;
         count_in = '0;
      end
   end

   assign store_wide = 64'(store_in);
   assign res_valid  = frame_done && (cmd_ff == cfg.speed_command);

   always_comb begin
      res.left_speed_bits   = store_wide[31:0];
      res.right_speed_bits  = store_wide[63:32];
      res.frame_length      = len_in;
      res.payload_truncated = (len_in > 16'(SPEED_BYTES));
   end

endmodule
